FILE: sv/tof_pkg.sv
// ----------------------------------------------------------------------------
// tof_pkg: shared types and constants of the terminal output formatter
// Configuration record, classified command word and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tof_pkg;

    localparam logic [6:0] CH_TAB      = 7'd9;
    localparam logic [6:0] CH_LF       = 7'd10;
    localparam logic [6:0] CH_CR       = 7'd13;
    localparam logic [6:0] CH_ESC      = 7'd27;
    localparam logic [6:0] CH_SPACE    = 7'd32;
    localparam logic [6:0] CH_DOLLAR   = 7'h24;
    localparam logic [6:0] CH_CARET    = 7'h5E;
    localparam logic [6:0] CTRL_OFFSET = 7'h40;

    // byte budget of one burst and the room a tab space may need (CR LF space)
    localparam logic [5:0] MAX_OUT       = 6'd32;
    localparam logic [5:0] SPACE_RESERVE = 6'd3;

    localparam logic [2:0] CFG_LINE_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_TAB_MASK      = 3'd1;
    localparam logic [2:0] CFG_TRUNCATE_MODE = 3'd2;
    localparam logic [2:0] CFG_IMAGE_MODE    = 3'd3;
    localparam logic [2:0] CFG_NOWRAP_LOW    = 3'd4;
    localparam logic [2:0] CFG_NOWRAP_HIGH   = 3'd5;

    typedef struct packed {
        logic [63:0] nowrap_high;
        logic [63:0] nowrap_low;
        logic        image_mode;
        logic        truncate_mode;
        logic [3:0]  tab_mask;
        logic [7:0]  line_width;
    } cfg_t;

    typedef enum logic [2:0] {
        K_PRINT,
        K_CR,
        K_LF,
        K_RAW,
        K_ESC,
        K_TAB,
        K_CTRL
    } kind_t;

    typedef struct packed {
        logic [6:0] code;
        kind_t      kind;
        logic       exempt;
    } cmd_t;

    // column advance, saturating at 255
    function automatic logic [7:0] col_add(input logic [7:0] col, input logic [1:0] k);
        logic [8:0] sum;
        sum = {1'b0, col} + {7'b0, k};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tof_front.sv
// ----------------------------------------------------------------------------
// tof_front: input acceptance and character classification
// Drops suppressed characters and turns the rest into command words.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_front (
    input  wire tof_pkg::cfg_t cfg,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [15:0]        s_tdata,   // [6:0] char_code, [7] command_done,
                                          // [8] output_suppressed
    input  wire                q_full,
    output logic               q_push,
    output tof_pkg::cmd_t      q_cmd
);

    logic [6:0]   code;
    logic         done;
    logic         suppressed;
    logic         raw;
    logic [127:0] nowrap_all;

    assign code       = s_tdata[6:0];
    assign done       = s_tdata[7];
    assign suppressed = s_tdata[8];
    assign raw        = cfg.image_mode && !done;
    assign nowrap_all = {cfg.nowrap_high, cfg.nowrap_low};

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && !suppressed;

    always_comb begin
        q_cmd.code   = code;
        q_cmd.exempt = (code == tof_pkg::CH_CR) || nowrap_all[code];
        if (code[6:5] != 2'b00) begin
            q_cmd.kind = tof_pkg::K_PRINT;
        end else if (code == tof_pkg::CH_CR) begin
            q_cmd.kind = tof_pkg::K_CR;
        end else if (code == tof_pkg::CH_LF) begin
            q_cmd.kind = tof_pkg::K_LF;
        end else if (raw) begin
            q_cmd.kind = tof_pkg::K_RAW;
        end else if (code == tof_pkg::CH_ESC) begin
            q_cmd.kind = tof_pkg::K_ESC;
        end else if (code == tof_pkg::CH_TAB) begin
            q_cmd.kind = tof_pkg::K_TAB;
        end else begin
            q_cmd.kind = tof_pkg::K_CTRL;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tof_queue.sv
// ----------------------------------------------------------------------------
// tof_queue: short command queue between front and back
// Circular buffer of classified commands with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_queue #(
    parameter int DEPTH = 2
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  wire tof_pkg::cmd_t din,
    output logic               full,
    input  wire                pop,
    output logic               valid,
    output tof_pkg::cmd_t      dout
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tof_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign valid   = (count_reg != '0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tof_back.sv
// ----------------------------------------------------------------------------
// tof_back: byte sequencer of the terminal output formatter
// Keeps the column, applies wrap or truncation, expands tabs and control
// codes, emits one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire tof_pkg::cfg_t cfg,
    input  wire                q_valid,
    input  wire tof_pkg::cmd_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [7:0]         m_tdata,   // [6:0] out_byte
    output logic               m_tlast    // last_byte
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WLF,
        S_BODY,
        S_CTRL2,
        S_TAB,
        S_TABLF,
        S_TABSP
    } state_t;

    state_t        state_reg, state_next;
    tof_pkg::cmd_t cur_reg, cur_next;
    logic [7:0]    col_reg, col_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          out_valid_reg;
    logic [6:0]    out_byte_reg;
    logic          out_last_reg;

    logic          free;
    logic          sp_exempt;
    logic          emit;
    logic [6:0]    emit_byte;
    logic          emit_last;
    logic          body_go, tab_go, space_go;
    tof_pkg::cmd_t body_cmd;
    logic [5:0]    cnt_base;
    logic [7:0]    col_sp;
    logic          tab_cont;

    assign free      = !out_valid_reg || m_tready;
    assign sp_exempt = cfg.nowrap_low[tof_pkg::CH_SPACE[5:0]];
    assign col_sp    = tof_pkg::col_add(col_reg, 2'd1);

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_byte  = tof_pkg::CH_SPACE;
        emit_last  = 1'b0;
        body_go    = 1'b0;
        tab_go     = 1'b0;
        space_go   = 1'b0;
        body_cmd   = cur_reg;
        cnt_base   = cnt_reg;
        tab_cont   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid && free) begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    cnt_base = '0;
                    cnt_next = '0;
                    if (col_reg >= cfg.line_width && !q_data.exempt) begin
                        // truncate mode drops the character with no bytes
                        if (!cfg.truncate_mode) begin
                            emit       = 1'b1;
                            emit_byte  = tof_pkg::CH_CR;
                            col_next   = '0;
                            cnt_next   = 6'd1;
                            state_next = S_WLF;
                        end
                    end else begin
                        body_go  = 1'b1;
                        body_cmd = q_data;
                    end
                end
            end
            S_WLF: begin
                if (free) begin
                    emit       = 1'b1;
                    emit_byte  = tof_pkg::CH_LF;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_BODY;
                end
            end
            S_BODY: begin
                if (free) begin
                    body_go = 1'b1;
                end
            end
            S_CTRL2: begin
                if (free) begin
                    emit       = 1'b1;
                    emit_byte  = cur_reg.code + tof_pkg::CTRL_OFFSET;
                    emit_last  = 1'b1;
                    col_next   = tof_pkg::col_add(col_reg, 2'd2);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TAB: begin
                if (free) begin
                    tab_go = 1'b1;
                end
            end
            S_TABLF: begin
                if (free) begin
                    emit       = 1'b1;
                    emit_byte  = tof_pkg::CH_LF;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_TABSP;
                end
            end
            S_TABSP: begin
                if (free) begin
                    space_go = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (body_go) begin
            state_next = S_IDLE;
            cnt_next   = cnt_base + 1'b1;
            case (body_cmd.kind)
                tof_pkg::K_CR: begin
                    emit      = 1'b1;
                    emit_byte = tof_pkg::CH_CR;
                    emit_last = 1'b1;
                    col_next  = '0;
                end
                tof_pkg::K_LF: begin
                    emit      = 1'b1;
                    emit_byte = tof_pkg::CH_LF;
                    emit_last = 1'b1;
                end
                tof_pkg::K_RAW: begin
                    emit      = 1'b1;
                    emit_byte = body_cmd.code;
                    emit_last = 1'b1;
                end
                tof_pkg::K_ESC: begin
                    emit      = 1'b1;
                    emit_byte = tof_pkg::CH_DOLLAR;
                    emit_last = 1'b1;
                    col_next  = col_sp;
                end
                tof_pkg::K_CTRL: begin
                    emit       = 1'b1;
                    emit_byte  = tof_pkg::CH_CARET;
                    state_next = S_CTRL2;
                end
                tof_pkg::K_TAB: begin
                    tab_go = 1'b1;
                end
                default: begin
                    emit      = 1'b1;
                    emit_byte = body_cmd.code;
                    emit_last = 1'b1;
                    col_next  = col_sp;
                end
            endcase
        end

        if (tab_go) begin
            if (col_reg >= cfg.line_width && !sp_exempt) begin
                if (cfg.truncate_mode) begin
                    // first space already overlong: tab yields nothing
                    cnt_next   = cnt_base;
                    state_next = S_IDLE;
                end else begin
                    emit       = 1'b1;
                    emit_byte  = tof_pkg::CH_CR;
                    col_next   = '0;
                    cnt_next   = cnt_base + 1'b1;
                    state_next = S_TABLF;
                end
            end else begin
                space_go = 1'b1;
            end
        end

        if (space_go) begin
            // look ahead so the final space carries the last flag
            tab_cont = ((col_sp[3:0] & cfg.tab_mask) != 4'd0)
                    && ((cnt_base + 1'b1 + tof_pkg::SPACE_RESERVE) <= tof_pkg::MAX_OUT)
                    && !(cfg.truncate_mode && col_sp >= cfg.line_width && !sp_exempt);
            emit       = 1'b1;
            emit_byte  = tof_pkg::CH_SPACE;
            emit_last  = !tab_cont;
            col_next   = col_sp;
            cnt_next   = cnt_base + 1'b1;
            state_next = tab_cont ? S_TAB : S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_byte_reg};
    assign m_tlast  = out_last_reg;

    a_wrap_lf_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && state_reg == S_WLF) |-> !emit_last)
        else $error("wrap LF flagged as last byte");

    a_burst_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (cnt_reg <= tof_pkg::MAX_OUT))
        else $error("burst exceeds byte budget");

    a_cr_clears_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_byte == tof_pkg::CH_CR) |=> (col_reg == 8'd0))
        else $error("column not cleared after CR");

endmodule

`default_nettype wire

FILE: sv/terminal_output_formatter.sv
// ----------------------------------------------------------------------------
// terminal_output_formatter: terminal character output with tab expansion
// and line wrap
//
// Input stream (s_*): one 7-bit character per request with its command_done
// and output_suppressed flags. Output stream (m_*): the terminal bytes caused
// by that character, m_tlast on the last one. Suppressed or truncated
// characters, and a tab whose first space is truncated, give no bytes.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 line_width, 1 tab_mask, 2 truncate_mode, 3 image_mode,
// 4 nowrap_mask_low, 5 nowrap_mask_high); write only while idle.
// Accepted characters pass through the command queue register and the
// sequencer to the output register. Throughput: the back-end sequencer emits
// one byte per cycle while m_tready does not stall it; an item gives 1 to 32
// bytes, one dropped on wrap still passes it; suppressed ones never reach it.
// The command queue (QUEUE_DEPTH entries) lets input be accepted while a
// burst is still being sent; a stall on m_tready holds the output register
// and the sequencer, and s_tready falls once the queue fills.
// Reset: column 0, queue and output empty, registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_output_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // [6:0] char_code, [7] command_done,
                                    // [8] output_suppressed
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [6:0] out_byte
    output logic        m_tlast,    // last_byte
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_wdata
);

    tof_pkg::cfg_t cfg_reg;
    tof_pkg::cmd_t front_cmd;
    tof_pkg::cmd_t q_data;
    logic          q_full, q_push, q_pop, q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width    <= 8'd80;
            cfg_reg.tab_mask      <= 4'd7;
            cfg_reg.truncate_mode <= 1'b0;
            cfg_reg.image_mode    <= 1'b0;
            cfg_reg.nowrap_low    <= 64'd1024;
            cfg_reg.nowrap_high   <= 64'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                tof_pkg::CFG_LINE_WIDTH:    cfg_reg.line_width    <= cfg_wdata[7:0];
                tof_pkg::CFG_TAB_MASK:      cfg_reg.tab_mask      <= cfg_wdata[3:0];
                tof_pkg::CFG_TRUNCATE_MODE: cfg_reg.truncate_mode <= cfg_wdata[0];
                tof_pkg::CFG_IMAGE_MODE:    cfg_reg.image_mode    <= cfg_wdata[0];
                tof_pkg::CFG_NOWRAP_LOW:    cfg_reg.nowrap_low    <= cfg_wdata;
                tof_pkg::CFG_NOWRAP_HIGH:   cfg_reg.nowrap_high   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tof_front u_front (
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    tof_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_data)
    );

    tof_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: verif/terminal_output_formatter_tb.sv
// ----------------------------------------------------------------------------
// terminal_output_formatter_tb: self-checking bench for the terminal formatter
// Streams characters through the block under several register settings and
// checks every terminal byte and its last marker against an in-bench model of
// the column counter, wrap, truncation, tab expansion and control display.
// ----------------------------------------------------------------------------

module terminal_output_formatter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 16;

    typedef struct {
        logic [6:0] code;
        logic       done;
        logic       sup;
    } key_item_t;

    typedef struct {
        logic [6:0] out_byte;
        logic       last_byte;
    } term_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    key_item_t  keys_pending[$];
    term_byte_t bytes_due[$];
    logic [6:0] burst_bytes[$];
    key_item_t  next_key;
    term_byte_t due;

    tof_pkg::cfg_t cfg_mirror;
    logic [7:0] line_col;
    int         pending_items  = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         mismatches     = 0;
    int         chars_sent     = 0;
    int         bytes_checked  = 0;
    int         settings_used  = 0;
    int         idle_cycles    = 0;

    terminal_output_formatter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // ---------------- terminal model ----------------

    function automatic bit code_exempt(logic [6:0] c);
        return c[6] ? cfg_mirror.nowrap_high[c[5:0]]
                    : cfg_mirror.nowrap_low[c[5:0]];
    endfunction

    function automatic void put_byte(logic [6:0] b);
        if (burst_bytes.size() < int'(tof_pkg::MAX_OUT))
            burst_bytes.push_back(b);
    endfunction

    function automatic void bump_col(int k);
        line_col = (int'(line_col) + k > 255) ? 8'hFF : 8'(int'(line_col) + k);
    endfunction

    // returns 0 when truncation drops the character
    function automatic bit pass_wrap(logic [6:0] c);
        if (line_col >= cfg_mirror.line_width && c != tof_pkg::CH_CR
                && !code_exempt(c)) begin
            if (cfg_mirror.truncate_mode)
                return 1'b0;
            put_byte(tof_pkg::CH_CR);
            put_byte(tof_pkg::CH_LF);
            line_col = 8'd0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_terminal(logic [6:0] ch, logic done, logic sup);
        bit raw;
        bit spacing;
        raw = cfg_mirror.image_mode && !done;
        burst_bytes.delete();
        if (sup || !pass_wrap(ch))
            return;
        if (ch[6:5] == 2'b00) begin
            case (ch)
                tof_pkg::CH_CR: begin
                    put_byte(ch);
                    line_col = 8'd0;
                end
                tof_pkg::CH_LF: put_byte(ch);
                default: begin
                    if (raw) begin
                        put_byte(ch);
                    end else if (ch == tof_pkg::CH_ESC) begin
                        put_byte(tof_pkg::CH_DOLLAR);
                        bump_col(1);
                    end else if (ch == tof_pkg::CH_TAB) begin
                        spacing = 1'b1;
                        while (spacing) begin
                            // keep room for CR LF plus the space itself
                            if (burst_bytes.size() + int'(tof_pkg::SPACE_RESERVE)
                                    > int'(tof_pkg::MAX_OUT)) begin
                                spacing = 1'b0;
                            end else if (!pass_wrap(tof_pkg::CH_SPACE)) begin
                                spacing = 1'b0;
                            end else begin
                                put_byte(tof_pkg::CH_SPACE);
                                bump_col(1);
                                spacing = (line_col & {4'd0, cfg_mirror.tab_mask})
                                          != 8'd0;
                            end
                        end
                    end else begin
                        put_byte(tof_pkg::CH_CARET);
                        put_byte(ch + tof_pkg::CTRL_OFFSET);
                        bump_col(2);
                    end
                end
            endcase
        end else begin
            put_byte(ch);
            bump_col(1);
        end
        foreach (burst_bytes[i])
            bytes_due.push_back('{burst_bytes[i], i == burst_bytes.size() - 1});
    endfunction

    // ---------------- request driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_terminal(s_tdata[6:0], s_tdata[7], s_tdata[8]);
                pending_items--;
                chars_sent++;
            end
            if (keys_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_key = keys_pending.pop_front();
                s_tdata  <= {7'd0, next_key.sup, next_key.done, next_key.code};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    // ---------------- byte monitor ----------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            bytes_checked++;
            if (bytes_due.size() == 0) begin
                $error("out_byte: nothing expected, got %h", m_tdata[6:0]);
                mismatches++;
            end else begin
                due = bytes_due.pop_front();
                if (m_tdata[6:0] !== due.out_byte) begin
                    $error("out_byte: expected %h, got %h", due.out_byte, m_tdata[6:0]);
                    mismatches++;
                end
                if (m_tlast !== due.last_byte) begin
                    $error("last_byte: expected %b, got %b", due.last_byte, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- sequencing ----------------

    task automatic queue_key(logic [6:0] code, logic done, logic sup);
        keys_pending.push_back('{code, done, sup});
        pending_items++;
    endtask

    // wait until every request is taken and every byte seen, then let the
    // back end finish any dropped character
    task automatic settle();
        do @(negedge aclk); while (pending_items != 0 || bytes_due.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            tof_pkg::CFG_LINE_WIDTH:    cfg_mirror.line_width    = val[7:0];
            tof_pkg::CFG_TAB_MASK:      cfg_mirror.tab_mask      = val[3:0];
            tof_pkg::CFG_TRUNCATE_MODE: cfg_mirror.truncate_mode = val[0];
            tof_pkg::CFG_IMAGE_MODE:    cfg_mirror.image_mode    = val[0];
            tof_pkg::CFG_NOWRAP_LOW:    cfg_mirror.nowrap_low    = val;
            tof_pkg::CFG_NOWRAP_HIGH:   cfg_mirror.nowrap_high   = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [7:0] width, logic [3:0] mask, logic trunc,
                                 logic image, logic [63:0] low, logic [63:0] high);
        settle();
        write_reg(tof_pkg::CFG_LINE_WIDTH, {56'd0, width});
        write_reg(tof_pkg::CFG_TAB_MASK, {60'd0, mask});
        write_reg(tof_pkg::CFG_TRUNCATE_MODE, {63'd0, trunc});
        write_reg(tof_pkg::CFG_IMAGE_MODE, {63'd0, image});
        write_reg(tof_pkg::CFG_NOWRAP_LOW, low);
        write_reg(tof_pkg::CFG_NOWRAP_HIGH, high);
        settings_used++;
    endtask

    initial begin
        logic [6:0] code;
        int         pick;
        int         tab_pct;

        cfg_mirror = '{nowrap_high: 64'd0, nowrap_low: 64'd1024, image_mode: 1'b0,
                       truncate_mode: 1'b0, tab_mask: 4'd7, line_width: 8'd80};
        line_col = 8'd0;
        send_idle_pct  = 18;
        recv_stall_pct = 77;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // narrow line, image mode on: display forms, raw controls, auto new line
        apply_setting(8'd16, 4'd7, 1'b0, 1'b1, 64'd1024, 64'd0);
        queue_key(7'h41, 1'b1, 1'b0);
        queue_key(7'h00, 1'b1, 1'b0);
        queue_key(7'h1F, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_ESC, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_TAB, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_ESC, 1'b0, 1'b0);
        queue_key(7'h01, 1'b0, 1'b0);
        queue_key(tof_pkg::CH_TAB, 1'b0, 1'b0);
        queue_key(7'h7F, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_SPACE, 1'b0, 1'b0);
        queue_key(7'h7E, 1'b1, 1'b0);
        queue_key(7'h60, 1'b1, 1'b0);
        queue_key(7'h5F, 1'b1, 1'b0);
        queue_key(7'h42, 1'b1, 1'b1);
        queue_key(7'h7F, 1'b0, 1'b1);
        queue_key(tof_pkg::CH_TAB, 1'b1, 1'b0);
        queue_key(7'h43, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_LF, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_CR, 1'b1, 1'b0);

        // truncate mode, everything but space exempt: tab cut short, then dropped
        apply_setting(8'd20, 4'd15, 1'b1, 1'b0, ~(64'd1 << 32), '1);
        queue_key(tof_pkg::CH_TAB, 1'b1, 1'b0);
        queue_key(7'h61, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_TAB, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_TAB, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_SPACE, 1'b1, 1'b0);
        queue_key(7'h05, 1'b1, 1'b0);
        queue_key(tof_pkg::CH_CR, 1'b1, 1'b0);

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct  = 77;
                recv_stall_pct = 18;
            end else if (p == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            tab_pct = 8;
            case (p)
                0: apply_setting(8'd80, 4'd7, 1'b0, 1'b0, 64'd1024, 64'd0);
                1: apply_setting(8'd16, 4'd3, 1'b1, 1'b1, {$urandom, $urandom},
                                 {$urandom, $urandom});
                2: apply_setting(8'd255, 4'd0, 1'b0, 1'b1, 64'd0, '1);
                3: begin
                    // all codes exempt: column runs into saturation, tabs hit burst cap
                    apply_setting(8'd16, 4'd15, 1'b0, 1'b0, '1, '1);
                    tab_pct = 60;
                end
                4: apply_setting(8'd40, 4'd15, 1'b1, 1'b1, 64'd0, 64'd0);
                default: apply_setting(8'($urandom_range(255, 16)), 4'($urandom_range(15)),
                                       1'($urandom_range(1)), 1'($urandom_range(1)),
                                       {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            for (int i = 0; i < 29; i++) begin
                pick = $urandom_range(99);
                if (pick < tab_pct)
                    code = tof_pkg::CH_TAB;
                else if (pick < tab_pct + 25)
                    code = 7'($urandom_range(31));
                else
                    code = 7'($urandom_range(127, 32));
                queue_key(code, 1'($urandom_range(1)), $urandom_range(99) < 8);
            end
        end

        settle();
        $display("Covered %0d characters under %0d register settings, %0d bytes checked",
                 chars_sent, settings_used, bytes_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
